/* rtl/waac_pkg.sv */
// shared constants, types and register indexes of the angle axis calibrator
package waac_pkg;

    localparam int ANGLE_BITS     = 12;
    localparam int AXIS_W         = 15;
    localparam int SPAN_W         = ANGLE_BITS + 1;
    localparam int PROD_W         = SPAN_W + AXIS_W;
    localparam int CMP_W          = 32;
    localparam int SMALL_SPAN     = 200;
    localparam int LOW_HIGH_LIMIT = 2000;
    localparam int DIV_STEPS      = 3;
    localparam int DIV_STAGES     = AXIS_W / DIV_STEPS;
    localparam int CFG_DATA_W     = (ANGLE_BITS > AXIS_W) ? ANGLE_BITS : AXIS_W;
    localparam int CFG_IDX_W      = 3;

    localparam int SPAN_LOW_RST   = 1370;
    localparam int SPAN_HIGH_RST  = 1500;
    localparam int AXIS_LOW_RST   = 0;
    localparam int AXIS_HIGH_RST  = 10000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd4;

    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [SPAN_W-1:0]     t_span;
    typedef logic [AXIS_W-1:0]     t_axis;
    typedef logic [PROD_W-1:0]     t_prod;

    typedef struct packed {
        logic neg;
    } t_div_tag;

endpackage

/* rtl/waac_in_if.sv */
// raw angle sample channel
interface waac_in_if import waac_pkg::*; ();
    logic   valid;
    logic   ready;
    t_angle raw_angle;

    modport source (output valid, output raw_angle, input ready);
    modport sink (input valid, input raw_angle, output ready);
endinterface

/* rtl/waac_out_if.sv */
// calibrated axis value channel
interface waac_out_if import waac_pkg::*; ();
    logic  valid;
    logic  ready;
    t_axis axis_value;

    modport source (output valid, output axis_value, input ready);
    modport sink (input valid, input axis_value, output ready);
endinterface

/* rtl/waac_divider.sv */
// pipelined restoring divider, a few quotient bits per stage
module waac_divider import waac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_prod    i_num,
    input  t_span    i_den,
    input  t_div_tag i_tag,
    output logic     o_valid,
    input  logic     i_ready,
    output t_axis    o_quot,
    output t_div_tag o_tag
);

    logic     r_vld [DIV_STAGES];
    t_span    r_rem [DIV_STAGES];
    t_axis    r_wrk [DIV_STAGES];
    t_span    r_den [DIV_STAGES];
    t_div_tag r_tag [DIV_STAGES];
    logic     rdy   [DIV_STAGES+1];

    assign rdy[DIV_STAGES] = i_ready;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic     n_vld_in;
        t_span    n_rem_in;
        t_axis    n_wrk_in;
        t_span    n_den_in;
        t_div_tag n_tag_in;
        t_span    n_rem;
        t_axis    n_wrk;

        if (k == 0) begin : g_first
            assign n_vld_in = i_valid;
            assign n_rem_in = i_num[PROD_W-1:AXIS_W];
            assign n_wrk_in = i_num[AXIS_W-1:0];
            assign n_den_in = i_den;
            assign n_tag_in = i_tag;
        end else begin : g_next
            assign n_vld_in = r_vld[k-1];
            assign n_rem_in = r_rem[k-1];
            assign n_wrk_in = r_wrk[k-1];
            assign n_den_in = r_den[k-1];
            assign n_tag_in = r_tag[k-1];
        end

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        always_comb begin
            logic [SPAN_W:0] t;
            logic            ge;
            n_rem = n_rem_in;
            n_wrk = n_wrk_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                t  = {n_rem, n_wrk[AXIS_W-1]};
                ge = (t >= {1'b0, n_den_in});
                if (ge) begin
                    n_rem = SPAN_W'(t - {1'b0, n_den_in});
                end else begin
                    n_rem = t[SPAN_W-1:0];
                end
                n_wrk = {n_wrk[AXIS_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_rem[k] <= n_rem;
                r_wrk[k] <= n_wrk;
                r_den[k] <= n_den_in;
                r_tag[k] <= n_tag_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_wrk[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem[DIV_STAGES-1] < r_den[DIV_STAGES-1]))
        else $error("divider remainder not below divisor");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_den[DIV_STAGES-1] != '0))
        else $error("divider saw a zero divisor");
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("divider refused a transaction without a stalled output");
`endif

endmodule

/* rtl/wrapped_angle_axis_calibrator_unit.sv */
// top level of the wrapped angle axis calibrator
//
//  port      | dir | handshake           | payload
//  ----------+-----+---------------------+-----------------------------------
//  i_sample  | in  | valid / ready       | raw_angle
//  o_result  | out | valid / ready       | axis_value
//  i_cfg_*   | in  | i_cfg_we, no wait   | i_cfg_idx, i_cfg_data
//
// one transaction per cycle while the output is not stalled; the registered stages in order:
// unwrap and clamp, multiply, five divider stages of three quotient bits, output
// synchronous active-low reset clears valids and loads the register defaults
// a stalled output holds every stage behind it; empty stages still fill
module wrapped_angle_axis_calibrator_unit import waac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    waac_in_if.sink               i_sample,
    waac_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_angle r_span_low;
    t_angle r_span_high;
    t_axis  r_axis_low;
    t_axis  r_axis_high;
    logic   r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_low  <= ANGLE_BITS'(SPAN_LOW_RST);
            r_span_high <= ANGLE_BITS'(SPAN_HIGH_RST);
            r_axis_low  <= AXIS_W'(AXIS_LOW_RST);
            r_axis_high <= AXIS_W'(AXIS_HIGH_RST);
            r_invert    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPAN_LOW:  r_span_low  <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_SPAN_HIGH: r_span_high <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_AXIS_LOW:  r_axis_low  <= i_cfg_data[AXIS_W-1:0];
                CFG_AXIS_HIGH: r_axis_high <= i_cfg_data[AXIS_W-1:0];
                CFG_INVERT:    r_invert    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake chain
    logic rdy_s1, rdy_s2, rdy_out, div_ready, div_valid;
    logic r_s1_vld, r_s2_vld, r_out_vld;

    assign rdy_out = !r_out_vld || o_result.ready;
    assign rdy_s2  = !r_s2_vld || div_ready;
    assign rdy_s1  = !r_s1_vld || rdy_s2;
    assign i_sample.ready = rdy_s1;

    // stage 1: unwrap, clamp, offset and span
    logic [CMP_W-1:0] span_diff;
    logic             wraps;
    t_span            lo_ext, top, v, vc, n_offset, span, n_den;
    logic             n_neg;
    t_axis            n_mag;

    assign span_diff = CMP_W'(r_span_high - r_span_low);
    assign wraps = (r_span_high < r_span_low)
                || ((span_diff < CMP_W'(SMALL_SPAN))
                    && (CMP_W'(r_span_high) < CMP_W'(LOW_HIGH_LIMIT)));
    assign lo_ext = {1'b0, r_span_low};
    assign top    = {wraps, r_span_high};
    assign v      = {wraps && (i_sample.raw_angle <= r_span_high), i_sample.raw_angle};
    assign vc     = (v < lo_ext) ? lo_ext : ((v > top) ? top : v);
    assign n_offset = vc - lo_ext;
    assign span   = top - lo_ext;
    // zero span gives a zero offset, so a unit divisor yields a zero quotient
    assign n_den  = (span == '0) ? SPAN_W'(1) : span;
    assign n_neg  = (r_axis_high < r_axis_low);
    assign n_mag  = n_neg ? (r_axis_low - r_axis_high) : (r_axis_high - r_axis_low);

    t_span    r_s1_offset, r_s1_den;
    t_axis    r_s1_mag;
    t_div_tag r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy_s1) begin
            r_s1_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1_offset  <= n_offset;
            r_s1_den     <= n_den;
            r_s1_mag     <= n_mag;
            r_s1_tag.neg <= n_neg;
        end
    end

    // stage 2: product
    t_prod    r_s2_prod;
    t_span    r_s2_den;
    t_div_tag r_s2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (rdy_s2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s2) begin
            r_s2_prod <= PROD_W'(r_s1_offset) * PROD_W'(r_s1_mag);
            r_s2_den  <= r_s1_den;
            r_s2_tag  <= r_s1_tag;
        end
    end

    // division
    t_axis    div_quot;
    t_div_tag div_tag;

    waac_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .o_ready (div_ready),
        .i_num   (r_s2_prod),
        .i_den   (r_s2_den),
        .i_tag   (r_s2_tag),
        .o_valid (div_valid),
        .i_ready (rdy_out),
        .o_quot  (div_quot),
        .o_tag   (div_tag)
    );

    // output stage: offset from axis low, optional reflection
    logic [AXIS_W+1:0] mapped, n_result;
    t_axis             r_out_value;

    assign mapped = div_tag.neg ? ({2'b00, r_axis_low} - {2'b00, div_quot})
                                : ({2'b00, r_axis_low} + {2'b00, div_quot});
    assign n_result = r_invert ? ({2'b00, r_axis_high} + {2'b00, r_axis_low} - mapped)
                               : mapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rdy_out) begin
            r_out_vld <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_out_value <= n_result[AXIS_W-1:0];
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.axis_value = r_out_value;

`ifndef SYNTHESIS
    a_result_in_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            ((o_result.axis_value >= r_axis_low) && (o_result.axis_value <= r_axis_high))
            || ((o_result.axis_value >= r_axis_high) && (o_result.axis_value <= r_axis_low)))
        else $error("result outside the axis range");
    a_stall_needs_blocked_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> (o_result.valid && !o_result.ready))
        else $error("input refused while output could drain");
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result valid straight after reset");
`endif

endmodule
